/* hw/rtl/ytpq_pkg.sv */
`default_nettype none

package ytpq_pkg;

    localparam int DEF_ROWS = 8;
    localparam int DEF_COLS = 8;

    localparam logic signed [31:0] EMPTY_CELL = 32'sh7fffffff;
    localparam logic signed [31:0] NEG_LIMIT  = 32'sh80000001;

    localparam int DIM_W   = 4;
    localparam int CFG_W   = 1;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 40;

    localparam logic [CFG_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_W-1:0] CFG_COLS = 1'b1;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_EXTRACT = 2'd1,
        REQ_FIND    = 2'd2,
        REQ_NOP     = 2'd3
    } req_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic signed [31:0] result_value;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/young_tableau_priority_queue.sv */
// Young tableau priority queue: insert (tuser 0), extract-min (tuser 1) and find (tuser 2)
// on signed 32-bit values held in one ROWS x COLS memory with registered reads. Each
// request gives one result on m_*. After reset a clearing pass writes every cell empty
// with s_tready low. An insert or extract walk does two neighbor reads and one write-back
// on the single memory port pair per step, and a find reads each cell that it visits. A
// refused or trivial request ends without a walk; a full walk covers the rows x cols
// region in use. The user must write rows_in_use and cols_in_use through cfg_* only
// while idle; the block itself does not enforce it.
`default_nettype none

module young_tableau_priority_queue
    import ytpq_pkg::*;
#(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0] cfg_wdata,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // value
    input  wire logic [1:0]       s_tuser,   // req_type
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata    // result_value, found, status, zero fill
);

    localparam int CELLS = ROWS * COLS;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic [DIM_W-1:0] rows_reg, cols_reg;
    logic [RW-1:0]    last_row;
    logic [CW-1:0]    last_col;
    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [31:0]      wdata, rdata;
    result_t          res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= DIM_W'(8);
            cols_reg <= DIM_W'(8);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ROWS: rows_reg <= cfg_wdata;
                CFG_COLS: cols_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // zero counts as one, anything above the array size as the full size
    always_comb begin
        if (rows_reg == '0) begin
            last_row = '0;
        end else if (int'(rows_reg) > ROWS) begin
            last_row = RW'(ROWS - 1);
        end else begin
            last_row = RW'(int'(rows_reg) - 1);
        end
        if (cols_reg == '0) begin
            last_col = '0;
        end else if (int'(cols_reg) > COLS) begin
            last_col = CW'(COLS - 1);
        end else begin
            last_col = CW'(int'(cols_reg) - 1);
        end
    end

    ytpq_ram #(.DEPTH(CELLS), .AW(AW)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    ytpq_seq #(.ROWS(ROWS), .COLS(COLS), .RW(RW), .CW(CW), .AW(AW)) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .last_row  (last_row),
        .last_col  (last_col),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_tuser),
        .in_value  (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .mem_we    (we),
        .mem_waddr (waddr),
        .mem_wdata (wdata),
        .mem_raddr (raddr),
        .mem_rdata (rdata)
    );

    assign m_tdata = {5'b0, res.status, res.found, res.result_value};

endmodule

`default_nettype wire

/* hw/rtl/ytpq_ram.sv */
`default_nettype none

module ytpq_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [31:0]        rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/ytpq_seq.sv */
`default_nettype none

module ytpq_seq
    import ytpq_pkg::*;
#(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS,
    parameter int RW   = 3,
    parameter int CW   = 3,
    parameter int AW   = 6
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [RW-1:0] last_row,
    input  wire logic [CW-1:0] last_col,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    in_req,
    input  wire logic [31:0]   in_value,
    output logic               out_valid,
    input  wire logic          out_ready,
    output result_t            out_res,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output logic [31:0]        mem_wdata,
    output logic [AW-1:0]      mem_raddr,
    input  wire logic [31:0]   mem_rdata
);

    localparam int CELLS = ROWS * COLS;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_CHK, S_RD_A, S_RD_B, S_DEC, S_FIN
    } state_t;

    state_t             state_reg;
    req_t               op_reg;
    logic signed [31:0] v_reg;
    logic signed [31:0] a_reg;
    logic [RW-1:0]      r_reg;
    logic [CW-1:0]      c_reg;
    logic [AW-1:0]      clr_reg;
    result_t            res_reg;
    logic               out_valid_reg;
    result_t            out_reg;

    logic signed [31:0] rd;
    logic signed [31:0] in_v;
    logic               has_left, has_top, has_down, has_right;
    logic               ins_left, ins_up, ext_down, ext_right;

    function automatic logic [AW-1:0] addr_of(input int r, input int c);
        return AW'(r * COLS + c);
    endfunction

    assign rd   = mem_rdata;
    assign in_v = in_value;
    assign has_left  = c_reg != '0;
    assign has_top   = r_reg != '0;
    assign has_down  = r_reg < last_row;
    assign has_right = c_reg < last_col;

    // a holds left/down neighbor, rd holds top/right neighbor
    assign ins_left  = has_left && (a_reg > v_reg) && (!has_top || a_reg >= rd);
    assign ins_up    = has_top && (rd > v_reg);
    assign ext_down  = has_down && (!has_right || rd >= a_reg);
    assign ext_right = has_right && (rd < EMPTY_CELL) && (!has_down || a_reg > rd);

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_of(int'(r_reg), int'(c_reg));
        mem_wdata = v_reg;
        mem_raddr = '0;
        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = EMPTY_CELL;
            end
            S_IDLE: begin
                if (req_t'(in_req) == REQ_INSERT) begin
                    mem_raddr = addr_of(int'(last_row), int'(last_col));
                end
            end
            S_RD_A: begin
                if (op_reg == REQ_INSERT) begin
                    mem_raddr = addr_of(int'(r_reg), int'(c_reg) - 1);
                end else if (op_reg == REQ_EXTRACT) begin
                    mem_raddr = addr_of(int'(r_reg) + 1, int'(c_reg));
                end else begin
                    mem_raddr = addr_of(int'(r_reg), int'(c_reg));
                end
            end
            S_RD_B: begin
                if (op_reg == REQ_INSERT) begin
                    mem_raddr = addr_of(int'(r_reg) - 1, int'(c_reg));
                end else begin
                    mem_raddr = addr_of(int'(r_reg), int'(c_reg) + 1);
                end
            end
            S_DEC: begin
                mem_we = 1'b1;
                if (op_reg == REQ_INSERT) begin
                    if (ins_left) begin
                        mem_wdata = a_reg;
                    end else if (ins_up) begin
                        mem_wdata = rd;
                    end
                end else begin
                    if (ext_down) begin
                        mem_wdata = a_reg;
                    end else if (ext_right) begin
                        mem_wdata = rd;
                    end else begin
                        mem_wdata = EMPTY_CELL;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready && state_reg != S_FIN) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(CELLS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_valid) begin
                        op_reg  <= req_t'(in_req);
                        v_reg   <= in_v;
                        if (req_t'(in_req) == REQ_NOP) begin
                            res_reg   <= '{status: ST_OK, found: 1'b0,
                                           result_value: EMPTY_CELL};
                            state_reg <= S_FIN;
                        end else if (req_t'(in_req) == REQ_INSERT
                                     && (in_v == EMPTY_CELL || in_v <= NEG_LIMIT)) begin
                            res_reg   <= '{status: ST_RANGE, found: 1'b0,
                                           result_value: EMPTY_CELL};
                            state_reg <= S_FIN;
                        end else begin
                            res_reg   <= '{status: ST_OK, found: 1'b0,
                                           result_value: EMPTY_CELL};
                            state_reg <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    case (op_reg)
                        REQ_INSERT: begin
                            r_reg <= last_row;
                            c_reg <= last_col;
                            if (rd != EMPTY_CELL) begin
                                res_reg.status <= ST_FULL;
                                state_reg      <= S_FIN;
                            end else begin
                                state_reg <= S_RD_A;
                            end
                        end
                        REQ_EXTRACT: begin
                            r_reg <= '0;
                            c_reg <= '0;
                            if (rd == EMPTY_CELL) begin
                                res_reg.status <= ST_EMPTY;
                                state_reg      <= S_FIN;
                            end else begin
                                res_reg.result_value <= rd;
                                v_reg                <= EMPTY_CELL;
                                state_reg            <= S_RD_A;
                            end
                        end
                        default: begin
                            r_reg <= '0;
                            c_reg <= last_col;
                            if (v_reg == EMPTY_CELL || v_reg < rd) begin
                                state_reg <= S_FIN;
                            end else begin
                                state_reg <= S_RD_A;
                            end
                        end
                    endcase
                end
                S_RD_A: begin
                    state_reg <= S_RD_B;
                end
                S_RD_B: begin
                    a_reg <= rd;
                    if (op_reg == REQ_FIND) begin
                        // staircase walk from the top-right corner
                        if (rd == v_reg) begin
                            res_reg.found <= 1'b1;
                            state_reg     <= S_FIN;
                        end else if (rd > v_reg && has_left) begin
                            c_reg     <= c_reg - 1'b1;
                            state_reg <= S_RD_A;
                        end else if (rd < v_reg && has_down) begin
                            r_reg     <= r_reg + 1'b1;
                            state_reg <= S_RD_A;
                        end else begin
                            state_reg <= S_FIN;
                        end
                    end else begin
                        state_reg <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (op_reg == REQ_INSERT) begin
                        if (ins_left) begin
                            c_reg     <= c_reg - 1'b1;
                            state_reg <= S_RD_A;
                        end else if (ins_up) begin
                            r_reg     <= r_reg - 1'b1;
                            state_reg <= S_RD_A;
                        end else begin
                            state_reg <= S_FIN;
                        end
                    end else begin
                        if (ext_down) begin
                            r_reg     <= r_reg + 1'b1;
                            state_reg <= S_RD_A;
                        end else if (ext_right) begin
                            c_reg     <= c_reg + 1'b1;
                            state_reg <= S_RD_A;
                        end else begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (!out_valid_reg || out_ready) begin
                        out_valid_reg <= 1'b1;
                        out_reg       <= res_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ytpq_chk.sv */
`default_nettype none

module ytpq_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    // a real minimum only comes with an ok extract
    a_value_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[31:0] != 32'h7fffffff |-> m_tdata[34:33] == 2'd0 && !m_tdata[32])
        else $error("extracted value with bad status or found flag");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tdata[34:33] == 2'd0 && m_tdata[31:0] == 32'h7fffffff)
        else $error("found flag with bad status or value");

    // clearing pass holds off requests right after reset
    a_clear: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("request taken during clearing pass");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind young_tableau_priority_queue ytpq_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
